// ===== rtl/lazt_pkg.sv =====
`default_nettype none

package lazt_pkg;

  localparam int RAW_W    = 20;
  localparam int Z_W      = 21;
  localparam int DIFF_W   = 21;
  localparam int SAMPLE_W = 14;
  localparam int SUM_W    = 15;
  localparam int MAG_W    = 14;
  localparam int SCALED_W = 21;
  localparam int RECIP_W  = 22;
  localparam int PROD_W   = SCALED_W + RECIP_W;
  localparam int AVG_W    = 15;
  localparam int SPEED_W  = 3;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  localparam logic REG_TRACKING_ENABLE = 1'b0;

  // sensor zero and accepted window, -15 mm < d <= +15 mm at 405 counts/mm
  localparam logic signed [DIFF_W-1:0] ZERO_OFFSET = 21'sd115218;
  localparam logic signed [DIFF_W-1:0] RANGE_LO    = -21'sd6074;
  localparam logic signed [DIFF_W-1:0] RANGE_HI    = 21'sd6075;

  // round(s*100/81) = floor((100*|s| + 40) / 81); 1/81 as K / 2^28, exact here
  localparam logic [SCALED_W-1:0] SCALE_MUL   = 21'd100;
  localparam logic [SCALED_W-1:0] SCALE_BIAS  = 21'd40;
  localparam logic [RECIP_W-1:0]  RECIP_K     = 22'd3314018;
  localparam int                  RECIP_SHIFT = 28;

  localparam logic [MAG_W-1:0] MOVE_MIN_UM = 14'd50;
  localparam logic [MAG_W-1:0] TIER5_UM    = 14'd5000;
  localparam logic [MAG_W-1:0] TIER4_UM    = 14'd3000;
  localparam logic [MAG_W-1:0] TIER3_UM    = 14'd1000;
  localparam logic [MAG_W-1:0] TIER2_UM    = 14'd500;
  localparam logic [MAG_W-1:0] TIER1_UM    = 14'd200;

  localparam logic signed [Z_W-1:0] Z_MAX = 21'sd1048575;
  localparam logic signed [Z_W-1:0] Z_MIN = -21'sd1048576;

  typedef enum logic [SPEED_W-1:0] {
    SPEED_0040 = 3'd0,
    SPEED_0100 = 3'd1,
    SPEED_0500 = 3'd2,
    SPEED_1200 = 3'd3,
    SPEED_3000 = 3'd4,
    SPEED_5000 = 3'd5
  } speed_t;

  typedef struct packed {
    logic                    in_range;
    logic                    track;
    logic signed [SUM_W-1:0] sum;
    logic signed [Z_W-1:0]   z;
  } sum_item_t;

  typedef struct packed {
    logic                  in_range;
    logic                  track;
    logic                  neg;
    logic [MAG_W-1:0]      mag;
    logic signed [Z_W-1:0] z;
  } mag_item_t;

endpackage

`default_nettype wire

// ===== rtl/lazt_cfg.sv =====
`default_nettype none

module lazt_cfg (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             psel,
  input  wire                             penable,
  input  wire                             pwrite,
  input  wire [lazt_pkg::ADDR_W-1:0]      paddr,
  input  wire [lazt_pkg::DATA_W-1:0]      pwdata,
  output logic [lazt_pkg::DATA_W-1:0]     prdata,
  output logic                            pready,
  output logic                            tracking_enable
);
  import lazt_pkg::*;

  logic enable_r, enable_nxt;
  logic reg_sel;

  assign reg_sel = (paddr[ADDR_W-1] == REG_TRACKING_ENABLE);

  always_comb begin
    enable_nxt = enable_r;
    if (psel && penable && pwrite && reg_sel) begin
      enable_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
    end else begin
      enable_r <= enable_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata = {{(DATA_W-1){1'b0}}, enable_r};
    end
  end

  assign pready          = 1'b1;
  assign tracking_enable = enable_r;

endmodule

`default_nettype wire

// ===== rtl/lazt_front.sv =====
`default_nettype none

module lazt_front (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              tracking_enable,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire                              in_command,
  input  wire [lazt_pkg::RAW_W-1:0]        in_sensor_raw,
  input  wire signed [lazt_pkg::Z_W-1:0]   in_z_position_um,
  output logic                             dn_valid,
  input  wire                              dn_ready,
  output lazt_pkg::sum_item_t              dn_item
);
  import lazt_pkg::*;

  // input register
  logic                    s1_valid_r, s1_valid_nxt;
  logic                    s1_cmd_r;
  logic [RAW_W-1:0]        s1_raw_r;
  logic signed [Z_W-1:0]   s1_z_r;
  logic                    s1_ready;

  // tracker state
  logic signed [SAMPLE_W-1:0] sample_a_r, sample_a_nxt;
  logic signed [SAMPLE_W-1:0] sample_b_r, sample_b_nxt;
  logic                       write_slot_r, write_slot_nxt;
  logic                       range_flag_r, range_flag_nxt;

  // sum register
  logic      s2_valid_r, s2_valid_nxt;
  sum_item_t s2_item_r, s2_item_nxt;

  logic                     s1_load, s2_load;
  logic signed [DIFF_W-1:0] diff;
  logic                     hit;

  assign s1_ready = !s2_valid_r || dn_ready;
  assign in_ready = !s1_valid_r || s1_ready;
  assign s1_load  = in_valid && in_ready;
  assign s2_load  = s1_valid_r && s1_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_load) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_ready) begin
      s1_valid_nxt = 1'b0;
    end
    s2_valid_nxt = s2_valid_r;
    if (s2_load) begin
      s2_valid_nxt = 1'b1;
    end else if (dn_ready) begin
      s2_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    diff           = $signed({1'b0, s1_raw_r}) - ZERO_OFFSET;
    hit            = (diff >= RANGE_LO) && (diff <= RANGE_HI);
    sample_a_nxt   = sample_a_r;
    sample_b_nxt   = sample_b_r;
    write_slot_nxt = write_slot_r;
    range_flag_nxt = range_flag_r;
    if (s1_cmd_r == CMD_SAMPLE) begin
      range_flag_nxt = hit;
      if (hit) begin
        if (write_slot_r) begin
          sample_b_nxt = diff[SAMPLE_W-1:0];
        end else begin
          sample_a_nxt = diff[SAMPLE_W-1:0];
        end
        write_slot_nxt = ~write_slot_r;
      end
    end
    s2_item_nxt.in_range = range_flag_nxt;
    s2_item_nxt.track    = (s1_cmd_r == CMD_TICK) && tracking_enable && range_flag_r;
    s2_item_nxt.sum      = SUM_W'(sample_a_nxt) + SUM_W'(sample_b_nxt);
    s2_item_nxt.z        = s1_z_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      sample_a_r   <= '0;
      sample_b_r   <= '0;
      write_slot_r <= 1'b0;
      range_flag_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
      if (s2_load) begin
        sample_a_r   <= sample_a_nxt;
        sample_b_r   <= sample_b_nxt;
        write_slot_r <= write_slot_nxt;
        range_flag_r <= range_flag_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_cmd_r <= in_command;
      s1_raw_r <= in_sensor_raw;
      s1_z_r   <= in_z_position_um;
    end
    if (s2_load) begin
      s2_item_r <= s2_item_nxt;
    end
  end

  assign dn_valid = s2_valid_r;
  assign dn_item  = s2_item_r;

endmodule

`default_nettype wire

// ===== rtl/lazt_scale.sv =====
`default_nettype none

module lazt_scale (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   up_valid,
  output logic                  up_ready,
  input  lazt_pkg::sum_item_t   up_item,
  output logic                  dn_valid,
  input  wire                   dn_ready,
  output lazt_pkg::mag_item_t   dn_item
);
  import lazt_pkg::*;

  logic      valid_r, valid_nxt;
  mag_item_t item_r, item_nxt;
  logic      load;

  logic signed [SUM_W-1:0] abs_sum;
  logic [SCALED_W-1:0]     scaled;
  logic [PROD_W-1:0]       prod;

  assign up_ready = !valid_r || dn_ready;
  assign load     = up_valid && up_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (dn_ready) begin
      valid_nxt = 1'b0;
    end
  end

  // |sum| * 100/81 rounded, via reciprocal multiply
  always_comb begin
    abs_sum = up_item.sum[SUM_W-1] ? -up_item.sum : up_item.sum;
    scaled  = SCALED_W'(abs_sum[MAG_W-1:0]) * SCALE_MUL + SCALE_BIAS;
    prod    = PROD_W'(scaled) * PROD_W'(RECIP_K);
    item_nxt.in_range = up_item.in_range;
    item_nxt.track    = up_item.track;
    item_nxt.neg      = up_item.sum[SUM_W-1];
    item_nxt.mag      = prod[RECIP_SHIFT +: MAG_W];
    item_nxt.z        = up_item.z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_item  = item_r;

endmodule

`default_nettype wire

// ===== rtl/lazt_out.sv =====
`default_nettype none

module lazt_out (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  up_valid,
  output logic                                 up_ready,
  input  lazt_pkg::mag_item_t                  up_item,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic                                 out_in_range,
  output logic signed [lazt_pkg::AVG_W-1:0]    out_average_um,
  output logic                                 out_speed_valid,
  output logic [lazt_pkg::SPEED_W-1:0]         out_speed_code,
  output logic                                 out_move_valid,
  output logic signed [lazt_pkg::Z_W-1:0]      out_target_um
);
  import lazt_pkg::*;

  logic                    valid_r, valid_nxt;
  logic                    in_range_r, in_range_nxt;
  logic signed [AVG_W-1:0] avg_r, avg_nxt;
  logic                    speed_valid_r, speed_valid_nxt;
  speed_t                  speed_r, speed_nxt;
  logic                    move_valid_r, move_valid_nxt;
  logic signed [Z_W-1:0]   target_r, target_nxt;
  logic                    load;

  speed_t                  tier;
  logic signed [AVG_W-1:0] mag_s;
  logic signed [Z_W:0]     target_wide;

  assign up_ready = !valid_r || out_ready;
  assign load     = up_valid && up_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_comb begin
    if (up_item.mag >= TIER5_UM) begin
      tier = SPEED_5000;
    end else if (up_item.mag >= TIER4_UM) begin
      tier = SPEED_3000;
    end else if (up_item.mag >= TIER3_UM) begin
      tier = SPEED_1200;
    end else if (up_item.mag >= TIER2_UM) begin
      tier = SPEED_0500;
    end else if (up_item.mag >= TIER1_UM) begin
      tier = SPEED_0100;
    end else begin
      tier = SPEED_0040;
    end

    mag_s       = $signed({1'b0, up_item.mag});
    avg_nxt     = up_item.neg ? -mag_s : mag_s;
    target_wide = (Z_W+1)'(up_item.z) + (Z_W+1)'(avg_nxt);

    in_range_nxt    = up_item.in_range;
    speed_valid_nxt = 1'b0;
    speed_nxt       = SPEED_0040;
    move_valid_nxt  = 1'b0;
    target_nxt      = '0;
    if (up_item.track) begin
      speed_valid_nxt = 1'b1;
      speed_nxt       = tier;
      if (up_item.mag >= MOVE_MIN_UM) begin
        move_valid_nxt = 1'b1;
        // saturate on overflow of the 21-bit target
        if (target_wide[Z_W] != target_wide[Z_W-1]) begin
          target_nxt = target_wide[Z_W] ? Z_MIN : Z_MAX;
        end else begin
          target_nxt = target_wide[Z_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      in_range_r    <= in_range_nxt;
      avg_r         <= avg_nxt;
      speed_valid_r <= speed_valid_nxt;
      speed_r       <= speed_nxt;
      move_valid_r  <= move_valid_nxt;
      target_r      <= target_nxt;
    end
  end

  assign out_valid       = valid_r;
  assign out_in_range    = in_range_r;
  assign out_average_um  = avg_r;
  assign out_speed_valid = speed_valid_r;
  assign out_speed_code  = speed_r;
  assign out_move_valid  = move_valid_r;
  assign out_target_um   = target_r;

endmodule

`default_nettype wire

// ===== rtl/laser_autofocus_z_tracker.sv =====
// channel  direction  handshake            payload
// in_      input      in_valid/in_ready    command, sensor_raw, z_position_um
// out_     output     out_valid/out_ready  in_range, average_um, speed_*, move_*, target_um
// cfg      input      APB psel/penable     tracking_enable at byte address 0
//
// One item per cycle sustained while out_ready is high; an accepted item passes the input
// register, then sample buffer update and sum, reciprocal multiply and tier/target.
// Synchronous active-low reset clears the sample buffer, slot, flag and enable.
// Each stage holds its item while the one after it is full and stalled, so in_ready stays high
// as long as any stage has room, including while a result waits on out_ready.
`default_nettype none

module laser_autofocus_z_tracker (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire                                in_command,
  input  wire [lazt_pkg::RAW_W-1:0]          in_sensor_raw,
  input  wire signed [lazt_pkg::Z_W-1:0]     in_z_position_um,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic                               out_in_range,
  output logic signed [lazt_pkg::AVG_W-1:0]  out_average_um,
  output logic                               out_speed_valid,
  output logic [lazt_pkg::SPEED_W-1:0]       out_speed_code,
  output logic                               out_move_valid,
  output logic signed [lazt_pkg::Z_W-1:0]    out_target_um,
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire [lazt_pkg::ADDR_W-1:0]         paddr,
  input  wire [lazt_pkg::DATA_W-1:0]         pwdata,
  output logic [lazt_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);
  import lazt_pkg::*;

  logic      tracking_enable;
  logic      sum_valid, sum_ready;
  sum_item_t sum_item;
  logic      mag_valid, mag_ready;
  mag_item_t mag_item;

  lazt_cfg u_cfg (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .tracking_enable (tracking_enable)
  );

  lazt_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .tracking_enable  (tracking_enable),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_sensor_raw    (in_sensor_raw),
    .in_z_position_um (in_z_position_um),
    .dn_valid         (sum_valid),
    .dn_ready         (sum_ready),
    .dn_item          (sum_item)
  );

  lazt_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (sum_valid),
    .up_ready (sum_ready),
    .up_item  (sum_item),
    .dn_valid (mag_valid),
    .dn_ready (mag_ready),
    .dn_item  (mag_item)
  );

  lazt_out u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .up_valid        (mag_valid),
    .up_ready        (mag_ready),
    .up_item         (mag_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_in_range    (out_in_range),
    .out_average_um  (out_average_um),
    .out_speed_valid (out_speed_valid),
    .out_speed_code  (out_speed_code),
    .out_move_valid  (out_move_valid),
    .out_target_um   (out_target_um)
  );

endmodule

`default_nettype wire
